// ----- hdl/bvema_pkg.sv -----
// ----------------------------------------------------------------------------
// bvema_pkg
// Shared types, widths, register indexes and reset values of the battery voltage EMA filter.
// ----------------------------------------------------------------------------
`default_nettype none

package bvema_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int FRAC_BITS   = 16;

    // Scaled product carries 12 + 14 fraction bits
    localparam int PROD_FRAC = 26;
    localparam int SHIFT     = PROD_FRAC - FRAC_BITS;
    localparam int STATE_W   = 16 + FRAC_BITS;

    localparam int PROD1_W  = SAMPLE_BITS + 16;
    localparam int PROD2_W  = SAMPLE_BITS + 32;
    localparam int SCALED_W = PROD2_W + 1 - SHIFT;
    localparam int SUM_W    = ((SCALED_W > STATE_W) ? SCALED_W : STATE_W) + 2;

    localparam int MUL_A_W = (PROD1_W > STATE_W) ? PROD1_W : STATE_W;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [MUL_B_W-1:0] ONE_Q16    = 17'h10000;
    localparam logic [15:0]        BLEND_RND  = 16'h8000;

    localparam logic [15:0] RST_DIV_RATIO        = 16'd23347;
    localparam logic [15:0] RST_CAL_GAIN         = 16'd18170;
    localparam logic [15:0] RST_CAL_OFFSET_MV    = 16'd810;
    localparam logic [15:0] RST_SMOOTHING_WEIGHT = 16'd14549;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_DIV_RATIO        = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_GAIN         = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_OFFSET_MV    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_WEIGHT = 8'd3;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_CLEAR  = 1'b1;

    typedef struct packed {
        logic                   req_type;
        logic [SAMPLE_BITS-1:0] sample_mv;
    } t_in;

    typedef struct packed {
        logic [15:0] battery_mv;
        logic        tracking_valid;
    } t_out;

    typedef struct packed {
        logic [15:0]        div_ratio_q12;
        logic [15:0]        cal_gain;
        logic signed [15:0] cal_offset_mv;
        logic [15:0]        smoothing_weight;
    } t_cfg;

endpackage

`default_nettype wire

// ----- hdl/battery_voltage_ema_filter_top.sv -----
// ----------------------------------------------------------------------------
// battery_voltage_ema_filter_top
// Battery voltage EMA filter: scales ADC samples and smooths them.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall with i_in_data (request type and
// ADC millivolt sample). Output channel: o_out_valid / i_out_stall with
// o_out_data (smoothed millivolts and tracking flag). Each input beat
// gives exactly one output beat.
// Config channel: i_cfg_valid / o_cfg_ready (always ready), register index
// and 16-bit data; write only while the filter is idle.
// All multiplications run through one shared registered multiplier under a
// small sequencer; o_in_stall is high while a beat is in flight.
// A clear goes straight to the done state; a seeding sample passes the
// M1, M2 and OFF states; a blended sample also passes M3, M4 and SUM.
// A new input beat is taken only once the sequencer is back in idle,
// after its result has been loaded into the output register.
// A finished result sits in the output register; while the receiver
// stalls, one further beat can be processed up to its final step.
// Reset (synchronous, active low) restores the default calibration and
// drops tracking; the first sample afterwards seeds the filter.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_voltage_ema_filter_top (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire bvema_pkg::t_in                   i_in_data,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output bvema_pkg::t_out                       o_out_data,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [bvema_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [15:0]                      i_cfg_data
);
    import bvema_pkg::*;

    t_cfg  v_cfg;
    t_out  v_res;
    logic  v_res_load;
    logic  v_out_busy;

    logic  r_out_valid, n_out_valid;
    t_out  r_out_data;

    assign o_cfg_ready = 1'b1;

    bvema_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (v_cfg)
    );

    assign v_out_busy = r_out_valid && i_out_stall;

    bvema_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (v_cfg),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_out_busy (v_out_busy),
        .o_res_load (v_res_load),
        .o_res_data (v_res)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (v_res_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_res_load) begin
            r_out_data <= v_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// ----- hdl/bvema_mul.sv -----
// ----------------------------------------------------------------------------
// bvema_mul
// Shared unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module bvema_mul (
    input  wire logic                           i_clk,
    input  wire logic [bvema_pkg::MUL_A_W-1:0]  i_a,
    input  wire logic [bvema_pkg::MUL_B_W-1:0]  i_b,
    output logic      [bvema_pkg::MUL_P_W-1:0]  o_p
);
    import bvema_pkg::*;

    logic [MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

// ----- hdl/bvema_cfg.sv -----
// ----------------------------------------------------------------------------
// bvema_cfg
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module bvema_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_wr_en,
    input  wire logic [bvema_pkg::CFG_IDX_W-1:0]  i_index,
    input  wire logic [15:0]                      i_data,
    output bvema_pkg::t_cfg                       o_cfg
);
    import bvema_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            case (i_index)
                REG_DIV_RATIO:        n_cfg.div_ratio_q12    = i_data;
                REG_CAL_GAIN:         n_cfg.cal_gain         = i_data;
                REG_CAL_OFFSET_MV:    n_cfg.cal_offset_mv    = i_data;
                REG_SMOOTHING_WEIGHT: n_cfg.smoothing_weight = i_data;
                default:              n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.div_ratio_q12    <= RST_DIV_RATIO;
            r_cfg.cal_gain         <= RST_CAL_GAIN;
            r_cfg.cal_offset_mv    <= RST_CAL_OFFSET_MV;
            r_cfg.smoothing_weight <= RST_SMOOTHING_WEIGHT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- hdl/bvema_core.sv -----
// ----------------------------------------------------------------------------
// bvema_core
// Sequencer and datapath: scale, offset, clamp and blend over one multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module bvema_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire bvema_pkg::t_cfg     i_cfg,
    input  wire logic                i_in_valid,
    input  wire bvema_pkg::t_in      i_in_data,
    output logic                     o_in_stall,
    input  wire logic                i_out_busy,
    output logic                     o_res_load,
    output bvema_pkg::t_out          o_res_data
);
    import bvema_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_M1   = 3'd1;  // sample * divider
    localparam logic [2:0] S_M2   = 3'd2;  // * gain
    localparam logic [2:0] S_OFF  = 3'd3;  // round, offset, clamp
    localparam logic [2:0] S_M3   = 3'd4;  // w * instant
    localparam logic [2:0] S_M4   = 3'd5;  // (1 - w) * old
    localparam logic [2:0] S_SUM  = 3'd6;  // blend and round
    localparam logic [2:0] S_DONE = 3'd7;

    localparam logic [STATE_W-1:0] STATE_MAX = '1;

    logic [2:0]             r_st, n_st;
    logic [SAMPLE_BITS-1:0] r_sample, n_sample;
    logic [STATE_W-1:0]     r_inst, n_inst;
    logic [STATE_W-1:0]     r_smooth, n_smooth;
    logic                   r_tracking, n_tracking;
    logic [MUL_P_W-1:0]     r_acc, n_acc;

    logic [MUL_A_W-1:0] v_a;
    logic [MUL_B_W-1:0] v_b;
    logic [MUL_P_W-1:0] v_p;

    logic [PROD2_W:0]         v_rnd;
    logic [SCALED_W-1:0]      v_scaled;
    logic signed [SUM_W-1:0]  v_off;
    logic signed [SUM_W-1:0]  v_sum;
    logic [STATE_W-1:0]       v_clamped;
    logic [MUL_P_W:0]         v_blend;

    logic v_accept;

    assign v_accept   = i_in_valid && (r_st == S_IDLE);
    assign o_in_stall = (r_st != S_IDLE);

    bvema_mul u_mul (
        .i_clk (i_clk),
        .i_a   (v_a),
        .i_b   (v_b),
        .o_p   (v_p)
    );

    // Operand select for the shared multiplier
    always_comb begin
        case (r_st)
            S_M1: begin
                v_a = MUL_A_W'(r_sample);
                v_b = MUL_B_W'(i_cfg.div_ratio_q12);
            end
            S_M2: begin
                v_a = MUL_A_W'(v_p[PROD1_W-1:0]);
                v_b = MUL_B_W'(i_cfg.cal_gain);
            end
            S_M3: begin
                v_a = MUL_A_W'(r_inst);
                v_b = MUL_B_W'(i_cfg.smoothing_weight);
            end
            S_M4: begin
                v_a = MUL_A_W'(r_smooth);
                v_b = ONE_Q16 - MUL_B_W'(i_cfg.smoothing_weight);
            end
            default: begin
                v_a = '0;
                v_b = '0;
            end
        endcase
    end

    // Scaling tail: round half up, add offset, clamp to state range
    always_comb begin
        v_rnd     = (PROD2_W+1)'(v_p[PROD2_W-1:0]) + ((PROD2_W+1)'(1) << (SHIFT - 1));
        v_scaled  = v_rnd[PROD2_W:SHIFT];
        v_off     = SUM_W'(i_cfg.cal_offset_mv) <<< FRAC_BITS;
        v_sum     = $signed(SUM_W'(v_scaled)) + v_off;
        if (v_sum < 0) begin
            v_clamped = '0;
        end else if (v_sum > $signed(SUM_W'(STATE_MAX))) begin
            v_clamped = STATE_MAX;
        end else begin
            v_clamped = v_sum[STATE_W-1:0];
        end
        v_blend = (MUL_P_W+1)'(r_acc) + (MUL_P_W+1)'(v_p) + (MUL_P_W+1)'(BLEND_RND);
    end

    always_comb begin
        n_st       = r_st;
        n_sample   = r_sample;
        n_inst     = r_inst;
        n_smooth   = r_smooth;
        n_tracking = r_tracking;
        n_acc      = r_acc;
        o_res_load = 1'b0;
        case (r_st)
            S_IDLE: begin
                if (v_accept) begin
                    n_sample = i_in_data.sample_mv;
                    if (i_in_data.req_type == REQ_CLEAR) begin
                        n_smooth   = '0;
                        n_tracking = 1'b0;
                        n_st       = S_DONE;
                    end else begin
                        n_st = S_M1;
                    end
                end
            end
            S_M1: n_st = S_M2;
            S_M2: n_st = S_OFF;
            S_OFF: begin
                n_inst = (r_sample == '0) ? '0 : v_clamped;
                if (!r_tracking) begin
                    n_smooth   = n_inst;
                    n_tracking = 1'b1;
                    n_st       = S_DONE;
                end else begin
                    n_st = S_M3;
                end
            end
            S_M3: n_st = S_M4;
            S_M4: begin
                n_acc = v_p;
                n_st  = S_SUM;
            end
            S_SUM: begin
                n_smooth = v_blend[STATE_W+15:16];
                n_st     = S_DONE;
            end
            S_DONE: begin
                if (!i_out_busy) begin
                    o_res_load = 1'b1;
                    n_st       = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= S_IDLE;
            r_smooth   <= '0;
            r_tracking <= 1'b0;
        end else begin
            r_st       <= n_st;
            r_smooth   <= n_smooth;
            r_tracking <= n_tracking;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample <= n_sample;
        r_inst   <= n_inst;
        r_acc    <= n_acc;
    end

    assign o_res_data.battery_mv     = r_smooth[FRAC_BITS +: 16];
    assign o_res_data.tracking_valid = r_tracking;

endmodule

`default_nettype wire
